// ===== rtl/dcct_pkg.sv =====
// ---------------------------------------------------------------------------
// dcct_pkg
// Shared constants and types for the day count to calendar time converter.
// ---------------------------------------------------------------------------
package dcct_pkg;

  // Pipeline depth, shared by both datapaths and the valid chain
  localparam int NSTG = 10;

  localparam int MAX_DAY_NUMBER = 10675199;
  localparam int MAX_TIME       = 8639999;
  localparam int EPOCH_SHIFT    = 94187;
  localparam int FIRST_YEAR     = 1601;
  localparam int LAST_FEB28     = 58;

  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_1Y   = 365;

  // Reciprocals floor(2^S / C); estimate is exact or one low while value < 2^S
  localparam int RCP_400Y = 114;     // S = 24
  localparam int RCP_4Y   = 44;      // S = 16
  localparam int RCP_100  = 167772;  // S = 24
  localparam int RCP_60S  = 2184;    // S = 17
  localparam int RCP_60M  = 34;      // S = 11

  // First day (0-based) of each month in a year that counts 29 Feb
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  typedef logic [NSTG-1:0] stage_en_t;

  // Delta-time side data carried alongside the date path
  typedef struct packed {
    logic        is_delta;
    logic        sat;
    logic [15:0] day;
  } dlt_t;

endpackage

// ===== rtl/dcct_date.sv =====
// ---------------------------------------------------------------------------
// dcct_date
// Date pipeline: day count to Gregorian year, month and day of month.
// ---------------------------------------------------------------------------
module dcct_date (
  input  logic                     clk,
  input  dcct_pkg::stage_en_t      adv,
  input  logic signed [24:0]       day_number,
  input  logic                     is_delta,
  output logic [14:0]              year,
  output logic [3:0]               month,
  output logic [15:0]              day,
  output logic                     is_delta_o,
  output logic                     days_saturated
);

  dcct_pkg::dlt_t dlt_nxt;
  dcct_pkg::dlt_t dlt_r [dcct_pkg::NSTG-1];

  logic [23:0] s0_d_nxt, s0_d_r;
  logic [30:0] s1_prod;
  logic [6:0]  s1_est_r;
  logic [23:0] s1_d_r;
  logic [23:0] s2_r_nxt;
  logic [6:0]  s2_est_r;
  logic [18:0] s2_r_r;
  logic [6:0]  s3_q_nxt, s3_q_r;
  logic [17:0] s3_d_nxt, s3_d_r;
  logic [1:0]  s4_c_nxt, s4_c_r;
  logic [15:0] s4_d_nxt, s4_d_r;
  logic [14:0] s4_y_nxt, s4_y_r;
  logic [20:0] s5_prod;
  logic [4:0]  s5_est_r;
  logic [15:0] s5_d_r;
  logic [14:0] s5_y_r;
  logic [1:0]  s5_c_r;
  logic [15:0] s6_r_nxt;
  logic [4:0]  s6_est_r;
  logic [11:0] s6_r_r;
  logic [14:0] s6_y_r;
  logic [1:0]  s6_c_r;
  logic [4:0]  s7_q_nxt, s7_q_r;
  logic [10:0] s7_d_nxt, s7_d_r;
  logic [14:0] s7_y_r;
  logic [1:0]  s7_c_r;
  logic [1:0]  s8_k;
  logic [8:0]  s8_doy;
  logic        s8_leap_ok;
  logic [8:0]  s8_doy_nxt, s8_doy_r;
  logic [14:0] s8_y_nxt, s8_y_r;
  logic [3:0]  s9_cnt;
  logic [14:0] year_nxt, year_r;
  logic [3:0]  month_nxt, month_r;
  logic [15:0] day_nxt, day_r;
  logic        sat_nxt, sat_r;
  logic        dl_r;

  // Stage 0: clamp, move the epoch to 1 Jan 1601, delta day count
  always_comb begin
    logic [24:0] nd;
    logic [23:0] dl;
    nd = 25'd0 - day_number;
    dl = (day_number[23:0] > 24'(dcct_pkg::MAX_DAY_NUMBER)) ?
         24'(dcct_pkg::MAX_DAY_NUMBER) : day_number[23:0];
    s0_d_nxt = dl + 24'(dcct_pkg::EPOCH_SHIFT);
    dlt_nxt.is_delta = is_delta;
    if (day_number[24]) begin
      dlt_nxt.sat = |nd[24:16];
      dlt_nxt.day = dlt_nxt.sat ? 16'hFFFF : nd[15:0];
    end else begin
      dlt_nxt.sat = 1'b0;
      dlt_nxt.day = 16'd0;
    end
  end

  assign s1_prod  = 31'(s0_d_r) * 31'(dcct_pkg::RCP_400Y);
  assign s2_r_nxt = s1_d_r - 24'(s1_est_r) * 24'(dcct_pkg::DAYS_400Y);

  always_comb begin
    if (s2_r_r >= 19'(dcct_pkg::DAYS_400Y)) begin
      s3_q_nxt = s2_est_r + 7'd1;
      s3_d_nxt = 18'(s2_r_r - 19'(dcct_pkg::DAYS_400Y));
    end else begin
      s3_q_nxt = s2_est_r;
      s3_d_nxt = s2_r_r[17:0];
    end
  end

  // Century: the last day of a 400-year period stays in the fourth century
  always_comb begin
    logic [17:0] base;
    s4_c_nxt = 2'(s3_d_r >= 18'(dcct_pkg::DAYS_100Y))
             + 2'(s3_d_r >= 18'(2 * dcct_pkg::DAYS_100Y))
             + 2'(s3_d_r >= 18'(3 * dcct_pkg::DAYS_100Y));
    case (s4_c_nxt)
      2'd0:    base = 18'd0;
      2'd1:    base = 18'(dcct_pkg::DAYS_100Y);
      2'd2:    base = 18'(2 * dcct_pkg::DAYS_100Y);
      default: base = 18'(3 * dcct_pkg::DAYS_100Y);
    endcase
    s4_d_nxt = 16'(s3_d_r - base);
    s4_y_nxt = 15'(dcct_pkg::FIRST_YEAR) + 15'(s3_q_r) * 15'd400 + 15'(s4_c_nxt) * 15'd100;
  end

  assign s5_prod  = 21'(s4_d_r) * 21'(dcct_pkg::RCP_4Y);
  assign s6_r_nxt = s5_d_r - 16'(s5_est_r) * 16'(dcct_pkg::DAYS_4Y);

  always_comb begin
    if (s6_r_r >= 12'(dcct_pkg::DAYS_4Y)) begin
      s7_q_nxt = s6_est_r + 5'd1;
      s7_d_nxt = 11'(s6_r_r - 12'(dcct_pkg::DAYS_4Y));
    end else begin
      s7_q_nxt = s6_est_r;
      s7_d_nxt = s6_r_r[10:0];
    end
  end

  // Year within the 4-year period; the leap day lives in its last year,
  // except in the century years that are not a multiple of 400
  always_comb begin
    logic [10:0] base;
    s8_k = 2'(s7_d_r >= 11'(dcct_pkg::DAYS_1Y))
         + 2'(s7_d_r >= 11'(2 * dcct_pkg::DAYS_1Y))
         + 2'(s7_d_r >= 11'(3 * dcct_pkg::DAYS_1Y));
    case (s8_k)
      2'd0:    base = 11'd0;
      2'd1:    base = 11'(dcct_pkg::DAYS_1Y);
      2'd2:    base = 11'(2 * dcct_pkg::DAYS_1Y);
      default: base = 11'(3 * dcct_pkg::DAYS_1Y);
    endcase
    s8_doy     = 9'(s7_d_r - base);
    s8_leap_ok = (s8_k == 2'd3) && !(s7_q_r == 5'd24 && s7_c_r != 2'd3);
    s8_doy_nxt = s8_doy + 9'd1
               + 9'((s8_doy > 9'(dcct_pkg::LAST_FEB28)) && !s8_leap_ok);
    s8_y_nxt   = s7_y_r + {8'd0, s7_q_r, 2'b00} + 15'(s8_k);
  end

  // Month from the start-of-month table; a delta result takes the delta day count instead
  always_comb begin
    s9_cnt = 4'd0;
    for (int m = 1; m < 12; m++) begin
      s9_cnt = s9_cnt + 4'(s8_doy_r > dcct_pkg::MONTH_START[m]);
    end
    if (dlt_r[8].is_delta) begin
      year_nxt  = 15'd0;
      month_nxt = 4'd0;
      day_nxt   = dlt_r[8].day;
      sat_nxt   = dlt_r[8].sat;
    end else begin
      year_nxt  = s8_y_r;
      month_nxt = s9_cnt + 4'd1;
      day_nxt   = 16'(s8_doy_r - dcct_pkg::MONTH_START[s9_cnt]);
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_d_r   <= s0_d_nxt;
      dlt_r[0] <= dlt_nxt;
    end
    for (int i = 1; i < dcct_pkg::NSTG - 1; i++) begin
      if (adv[i]) begin
        dlt_r[i] <= dlt_r[i-1];
      end
    end
    if (adv[1]) begin
      s1_est_r <= s1_prod[30:24];
      s1_d_r   <= s0_d_r;
    end
    if (adv[2]) begin
      s2_est_r <= s1_est_r;
      s2_r_r   <= s2_r_nxt[18:0];
    end
    if (adv[3]) begin
      s3_q_r <= s3_q_nxt;
      s3_d_r <= s3_d_nxt;
    end
    if (adv[4]) begin
      s4_c_r <= s4_c_nxt;
      s4_d_r <= s4_d_nxt;
      s4_y_r <= s4_y_nxt;
    end
    if (adv[5]) begin
      s5_est_r <= s5_prod[20:16];
      s5_d_r   <= s4_d_r;
      s5_y_r   <= s4_y_r;
      s5_c_r   <= s4_c_r;
    end
    if (adv[6]) begin
      s6_est_r <= s5_est_r;
      s6_r_r   <= s6_r_nxt[11:0];
      s6_y_r   <= s5_y_r;
      s6_c_r   <= s5_c_r;
    end
    if (adv[7]) begin
      s7_q_r <= s7_q_nxt;
      s7_d_r <= s7_d_nxt;
      s7_y_r <= s6_y_r;
      s7_c_r <= s6_c_r;
    end
    if (adv[8]) begin
      s8_doy_r <= s8_doy_nxt;
      s8_y_r   <= s8_y_nxt;
    end
    if (adv[9]) begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      sat_r   <= sat_nxt;
      dl_r    <= dlt_r[8].is_delta;
    end
  end

  assign year           = year_r;
  assign month          = month_r;
  assign day            = day_r;
  assign is_delta_o     = dl_r;
  assign days_saturated = sat_r;

endmodule

// ===== rtl/dcct_tod.sv =====
// ---------------------------------------------------------------------------
// dcct_tod
// Time-of-day pipeline: hundredths of a second to h, min, s and 1/100 s.
// ---------------------------------------------------------------------------
module dcct_tod (
  input  logic                     clk,
  input  dcct_pkg::stage_en_t      adv,
  input  logic signed [24:0]       day_hundredths,
  input  logic                     is_delta,
  output logic [4:0]               hours,
  output logic [5:0]               minutes,
  output logic [5:0]               seconds,
  output logic [6:0]               hundredths
);

  logic [23:0] s0_t_nxt, s0_t_r;
  logic [40:0] s1_prod;
  logic [16:0] s1_est_r;
  logic [23:0] s1_t_r;
  logic [23:0] s2_r_nxt;
  logic [16:0] s2_est_r;
  logic [7:0]  s2_r_r;
  logic [16:0] s3_s_nxt, s3_s_r;
  logic [6:0]  s3_h_nxt, s3_h_r;
  logic [27:0] s4_prod;
  logic [10:0] s4_est_r;
  logic [16:0] s4_s_r;
  logic [6:0]  s4_h_r;
  logic [16:0] s5_r_nxt;
  logic [10:0] s5_est_r;
  logic [6:0]  s5_r_r;
  logic [6:0]  s5_h_r;
  logic [10:0] s6_m_nxt, s6_m_r;
  logic [5:0]  s6_sec_nxt, s6_sec_r;
  logic [6:0]  s6_h_r;
  logic [15:0] s7_prod;
  logic [4:0]  s7_est_r;
  logic [10:0] s7_m_r;
  logic [5:0]  s7_sec_r;
  logic [6:0]  s7_h_r;
  logic [10:0] s8_r_nxt;
  logic [4:0]  s8_est_r;
  logic [6:0]  s8_r_r;
  logic [5:0]  s8_sec_r;
  logic [6:0]  s8_h_r;
  logic [4:0]  hr_nxt, hr_r;
  logic [5:0]  min_nxt, min_r;
  logic [5:0]  sec_r;
  logic [6:0]  hs_r;

  // Stage 0: negate for a delta, clamp to one day
  always_comb begin
    logic signed [25:0] t;
    t = is_delta ? (26'sd0 - 26'(day_hundredths)) : 26'(day_hundredths);
    if (t[25]) begin
      s0_t_nxt = 24'd0;
    end else if (t[24:0] > 25'(dcct_pkg::MAX_TIME)) begin
      s0_t_nxt = 24'(dcct_pkg::MAX_TIME);
    end else begin
      s0_t_nxt = t[23:0];
    end
  end

  assign s1_prod  = 41'(s0_t_r) * 41'(dcct_pkg::RCP_100);
  assign s2_r_nxt = s1_t_r - 24'(s1_est_r) * 24'd100;

  always_comb begin
    if (s2_r_r >= 8'd100) begin
      s3_s_nxt = s2_est_r + 17'd1;
      s3_h_nxt = 7'(s2_r_r - 8'd100);
    end else begin
      s3_s_nxt = s2_est_r;
      s3_h_nxt = s2_r_r[6:0];
    end
  end

  assign s4_prod  = 28'(s3_s_r) * 28'(dcct_pkg::RCP_60S);
  assign s5_r_nxt = s4_s_r - 17'(s4_est_r) * 17'd60;

  always_comb begin
    if (s5_r_r >= 7'd60) begin
      s6_m_nxt   = s5_est_r + 11'd1;
      s6_sec_nxt = 6'(s5_r_r - 7'd60);
    end else begin
      s6_m_nxt   = s5_est_r;
      s6_sec_nxt = s5_r_r[5:0];
    end
  end

  assign s7_prod  = 16'(s6_m_r) * 16'(dcct_pkg::RCP_60M);
  assign s8_r_nxt = s7_m_r - 11'(s7_est_r) * 11'd60;

  always_comb begin
    if (s8_r_r >= 7'd60) begin
      hr_nxt  = s8_est_r + 5'd1;
      min_nxt = 6'(s8_r_r - 7'd60);
    end else begin
      hr_nxt  = s8_est_r;
      min_nxt = s8_r_r[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_t_r <= s0_t_nxt;
    end
    if (adv[1]) begin
      s1_est_r <= s1_prod[40:24];
      s1_t_r   <= s0_t_r;
    end
    if (adv[2]) begin
      s2_est_r <= s1_est_r;
      s2_r_r   <= s2_r_nxt[7:0];
    end
    if (adv[3]) begin
      s3_s_r <= s3_s_nxt;
      s3_h_r <= s3_h_nxt;
    end
    if (adv[4]) begin
      s4_est_r <= s4_prod[27:17];
      s4_s_r   <= s3_s_r;
      s4_h_r   <= s3_h_r;
    end
    if (adv[5]) begin
      s5_est_r <= s4_est_r;
      s5_r_r   <= s5_r_nxt[6:0];
      s5_h_r   <= s4_h_r;
    end
    if (adv[6]) begin
      s6_m_r   <= s6_m_nxt;
      s6_sec_r <= s6_sec_nxt;
      s6_h_r   <= s5_h_r;
    end
    if (adv[7]) begin
      s7_est_r <= s7_prod[15:11];
      s7_m_r   <= s6_m_r;
      s7_sec_r <= s6_sec_r;
      s7_h_r   <= s6_h_r;
    end
    if (adv[8]) begin
      s8_est_r <= s7_est_r;
      s8_r_r   <= s8_r_nxt[6:0];
      s8_sec_r <= s7_sec_r;
      s8_h_r   <= s7_h_r;
    end
    if (adv[9]) begin
      hr_r  <= hr_nxt;
      min_r <= min_nxt;
      sec_r <= s8_sec_r;
      hs_r  <= s8_h_r;
    end
  end

  assign hours      = hr_r;
  assign minutes    = min_r;
  assign seconds    = sec_r;
  assign hundredths = hs_r;

endmodule

// ===== rtl/day_count_to_calendar_time_unit.sv =====
// ---------------------------------------------------------------------------
// day_count_to_calendar_time_unit
// Converts a day count and time of day into Gregorian date and clock time.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one request per accepted beat; in_tdata carries the signed day
//           count since 17 Nov 1858 and the signed time of day in 1/100 s.
//           A negative value in either field marks a delta time.
//   out_* : one result per request, in request order; out_tuser flags delta
//           results and a saturated delta day count.
//   The date and time paths are ten-stage pipelines of constant-reciprocal
//   divisions running side by side, so one request is taken every cycle
//   while out_tready is high.
//   Each stage holds its item until the stage after it has room; a stalled
//   out_tready lets the bubbles ahead of the stall fill, and in_tready falls
//   only once all ten stages hold an item.
//   Reset clears the stage valid bits; in_tready is high straight after it.
// ---------------------------------------------------------------------------
module day_count_to_calendar_time_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // day_number[24:0], day_hundredths[49:25], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // year[14:0], month[18:15], day[34:19], hours[39:35],
                                  // minutes[45:40], seconds[51:46], hundredths[58:52], pad
  output logic [1:0]  out_tuser   // is_delta[0], days_saturated[1]
);

  logic [dcct_pkg::NSTG-1:0] v_r;
  logic [dcct_pkg::NSTG:0]   rdy;
  dcct_pkg::stage_en_t       adv;
  logic signed [24:0]        day_number;
  logic signed [24:0]        day_hundredths;
  logic                      is_delta;

  logic [14:0] year;
  logic [3:0]  month;
  logic [15:0] day;
  logic        dl_out;
  logic        sat_out;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [6:0]  hundredths;

  assign day_number     = in_tdata[24:0];
  assign day_hundredths = in_tdata[49:25];
  assign is_delta       = day_number[24] | day_hundredths[24];

  // A stage may load when it is empty or its item moves on
  always_comb begin
    rdy[dcct_pkg::NSTG] = out_tready;
    for (int i = dcct_pkg::NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign adv       = rdy[dcct_pkg::NSTG-1:0];
  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < dcct_pkg::NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  dcct_date u_date (
    .clk            (clk),
    .adv            (adv),
    .day_number     (day_number),
    .is_delta       (is_delta),
    .year           (year),
    .month          (month),
    .day            (day),
    .is_delta_o     (dl_out),
    .days_saturated (sat_out)
  );

  dcct_tod u_tod (
    .clk            (clk),
    .adv            (adv),
    .day_hundredths (day_hundredths),
    .is_delta       (is_delta),
    .hours          (hours),
    .minutes        (minutes),
    .seconds        (seconds),
    .hundredths     (hundredths)
  );

  assign out_tvalid = v_r[dcct_pkg::NSTG-1];
  assign out_tdata  = {5'd0, hundredths, seconds, minutes, hours, day, month, year};
  assign out_tuser  = {sat_out, dl_out};

  // Delta results carry no year or month
  a_delta_no_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[18:0] == 19'd0)
    else $error("delta result with a year or month");

  // Saturation only ever applies to a delta day count
  a_sat_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("saturation flag on an absolute date");

  // Absolute dates land on a real month and day of month
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[18:15] >= 4'd1 && out_tdata[18:15] <= 4'd12 &&
      out_tdata[34:19] >= 16'd1 && out_tdata[34:19] <= 16'd31)
    else $error("month or day of month out of range");

  // Clock fields stay within a day
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:35] <= 5'd23 && out_tdata[45:40] <= 6'd59 &&
      out_tdata[51:46] <= 6'd59 && out_tdata[58:52] <= 7'd99)
    else $error("time field out of range");

  // Back-pressure reaches the input only with every stage full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !out_tready)
    else $error("input stalled with an empty stage");

endmodule

// ===== sim/day_count_to_calendar_time_unit_tb.sv =====
// ---------------------------------------------------------------------------
// day_count_to_calendar_time_unit_tb
// Self-checking bench for the day count to calendar time converter. Requests
// are driven on the in_ stream with random gaps and results are taken from
// the out_ stream under random back-pressure. Every accepted request is run
// through a local calendar predictor, and each result is checked field by
// field against the oldest prediction still waiting.
// ---------------------------------------------------------------------------

typedef struct packed {
  logic [14:0] year;
  logic [3:0]  month;
  logic [15:0] day;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [6:0]  hundredths;
  logic        is_delta;
  logic        days_saturated;
} calendar_t;

class calendar_scoreboard;
  calendar_t   awaited[$];
  int unsigned errors = 0;

  function calendar_t convert_day_count(logic signed [24:0] dn, logic signed [24:0] th);
    int        month_len [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    calendar_t r;
    longint    d, t, y, q, k, nd;
    int        m;
    r = '0;
    d = longint'(dn);
    t = longint'(th);
    if (d < 0 || t < 0) begin
      nd = -d;
      r.is_delta = 1'b1;
      if (nd < 0) nd = 0;
      if (nd > 65535) begin
        nd = 65535;
        r.days_saturated = 1'b1;
      end
      r.day = nd[15:0];
      t = -t;
    end else begin
      if (d > dcct_pkg::MAX_DAY_NUMBER) d = dcct_pkg::MAX_DAY_NUMBER;
      // count from 1 Jan 1601, the start of a 400-year cycle
      d = d + dcct_pkg::EPOCH_SHIFT;
      y = dcct_pkg::FIRST_YEAR + (d / dcct_pkg::DAYS_400Y) * 400;
      d = d % dcct_pkg::DAYS_400Y;
      q = d / dcct_pkg::DAYS_100Y;
      if (q == 4) q = 3;
      d = d - q * dcct_pkg::DAYS_100Y;
      y = y + q * 100;
      y = y + (d / dcct_pkg::DAYS_4Y) * 4;
      d = d % dcct_pkg::DAYS_4Y;
      k = d / dcct_pkg::DAYS_1Y;
      if (k == 4) k = 3;
      d = d - k * dcct_pkg::DAYS_1Y;
      y = y + k;
      // month table counts 29 Feb; skip it in common years
      if (d > dcct_pkg::LAST_FEB28) begin
        if (k != 3 || ((y % 100) == 0 && (y % 400) != 0)) d = d + 1;
      end
      d = d + 1;
      m = 0;
      while (m < 11 && d > month_len[m]) begin
        d = d - month_len[m];
        m = m + 1;
      end
      r.year  = y[14:0];
      r.month = 4'(m + 1);
      r.day   = d[15:0];
    end
    if (t < 0) t = 0;
    if (t > dcct_pkg::MAX_TIME) t = dcct_pkg::MAX_TIME;
    r.hundredths = 7'(t % 100);
    t = t / 100;
    r.seconds = 6'(t % 60);
    t = t / 60;
    r.minutes = 6'(t % 60);
    r.hours   = 5'(t / 60);
    return r;
  endfunction

  function void note_request(logic [24:0] dn, logic [24:0] th);
    awaited.push_back(convert_day_count(dn, th));
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [63:0] data, logic [1:0] user);
    calendar_t want;
    if (awaited.size() == 0) begin
      $error("result with no request outstanding: tdata %h tuser %b", data, user);
      errors++;
      return;
    end
    want = awaited.pop_front();
    compare_field("year",           want.year,           data[14:0]);
    compare_field("month",          want.month,          data[18:15]);
    compare_field("day",            want.day,            data[34:19]);
    compare_field("hours",          want.hours,          data[39:35]);
    compare_field("minutes",        want.minutes,        data[45:40]);
    compare_field("seconds",        want.seconds,        data[51:46]);
    compare_field("hundredths",     want.hundredths,     data[58:52]);
    compare_field("is_delta",       want.is_delta,       user[0]);
    compare_field("days_saturated", want.days_saturated, user[1]);
  endfunction
endclass

module day_count_to_calendar_time_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1530;
  localparam int IDLE_LIMIT      = 4000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  calendar_scoreboard sb = new();
  int unsigned        cycle_count = 0;
  int unsigned        req_count   = 0;
  int                 stall_left  = 0;
  int                 idle_cycles = 0;

  day_count_to_calendar_time_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // calm stretches: no gaps at all for a while
  function automatic int pick_gap(int unsigned idx);
    int unsigned r;
    if (((idx / 150) % 3) == 0) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_request(logic [24:0] dn, logic [24:0] th);
    int gap;
    gap = pick_gap(req_count);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, th, dn};
    do @(posedge clk); while (!in_tready);
    sb.note_request(dn, th);
    req_count++;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic signed [24:0] dn, th;
    int unsigned        sel;
    int                 pos [8] = '{58, 59, 365, 1459, 1460, 36523, 36524, 146096};
    int                 p;
    sel = $urandom_range(99);
    dn  = 25'($urandom);
    th  = 25'($urandom);
    if (sel < 40) begin
      dn = 25'($urandom_range(dcct_pkg::MAX_DAY_NUMBER));
      th = 25'($urandom_range(dcct_pkg::MAX_TIME));
    end else if (sel < 52) begin
      dn = 25'(-int'($urandom_range(70000)));
      th = $urandom_range(1) ? 25'(-int'($urandom_range(dcct_pkg::MAX_TIME)))
                             : 25'(int'($urandom_range(dcct_pkg::MAX_TIME)));
    end else if (sel < 60) begin
      dn = 25'($urandom_range(dcct_pkg::MAX_DAY_NUMBER));
      th = 25'(-int'($urandom_range(dcct_pkg::MAX_TIME)));
    end else if (sel < 68) begin
      dn = 25'($urandom_range(25'h0FF_FFFF, dcct_pkg::MAX_DAY_NUMBER));
      th = 25'($urandom_range(25'h0FF_FFFF, dcct_pkg::MAX_TIME - 100));
    end else if (sel < 85) begin
      // close to leap-day, year, century and cycle boundaries
      p = pos[$urandom_range(7)];
      if (p < 36523 && $urandom_range(1)) begin
        p = p + 1461 * $urandom_range(23) + 36524 * $urandom_range(3);
      end
      dn = 25'(int'($urandom_range(73, 1)) * dcct_pkg::DAYS_400Y + p
               - dcct_pkg::EPOCH_SHIFT);
      th = 25'($urandom_range(dcct_pkg::MAX_TIME));
    end
    send_request(dn, th);
  endtask

  // receiver back-pressure, with calm stretches
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (((cycle_count / 256) % 4) == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < 75) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(99) < 90) ? $urandom_range(2, 0) : $urandom_range(40, 8);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    do begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end while (idle_cycles < IDLE_LIMIT);
    $display("day_count_to_calendar_time_unit_tb: FAIL");
    $finish;
  end

  initial begin
    int dir_days [20] = '{
      0, 10675199, 16777215, 10675200, -1, -65535, -65536, -16777216, 5, 0,
      -10675199, 51603, 15078, 15079, 51909, 53370, 51543, 0, 100, 50448
    };
    int dir_time [20] = '{
      0, 8639999, 0, 16777215, 0, 0, 8639999, -16777216, -1, -8639999,
      -1, 4500, 8639999, 0, 359999, 8640000, 1, -16777216, 6000, 4321999
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_days[i]) send_request(25'(dir_days[i]), 25'(dir_time[i]));
    wait_for_drain();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) wait_for_drain();
      send_random_request();
    end
    in_tvalid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (2 * dcct_pkg::NSTG) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      $error("%0d results never arrived", sb.awaited.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("day_count_to_calendar_time_unit_tb: PASS");
    end else begin
      $display("day_count_to_calendar_time_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
